// ----- src/ipv4h_pkg.sv -----
package ipv4h_pkg;

  localparam int MAX_PROTOCOL = 17;
  localparam int TABLE_DEPTH  = MAX_PROTOCOL + 1;
  localparam int TBL_IDX_W    = $clog2(TABLE_DEPTH);

  localparam logic [31:0] OWN_ADDRESS_RESET = 32'hc0a8_0b0b;
  localparam logic [3:0]  IP_VERSION        = 4'd4;
  localparam logic [7:0]  SEND_TTL          = 8'd64;
  localparam logic [15:0] HEADER_BYTES      = 16'd20;
  localparam logic [15:0] HEADER_WORD0      = {IP_VERSION, HEADER_BYTES[5:2], 8'h00};

  localparam int HEADER_WORDS = 10;
  localparam int WORD_IDX_W   = $clog2(HEADER_WORDS);
  localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = WORD_IDX_W'(HEADER_WORDS - 1);
  localparam logic [WORD_IDX_W-1:0] CSUM_WORD_IDX = WORD_IDX_W'(5);
  localparam int CSUM_SUM_W   = 20;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_RECEIVE  = 2'd1,
    CMD_SEND     = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DROP    = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_WORD    = 2'd2
  } kind_t;

  typedef struct packed {
    logic active;
    logic advance;
  } send_ctrl_t;

  typedef struct packed {
    logic [7:0] box;
    logic [7:0] tag;
    logic       in_range;
  } table_rd_t;

endpackage

// ----- src/ipv4h_table.sv -----
module ipv4h_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [7:0]           wr_protocol,
  input  logic [7:0]           wr_box,
  input  logic [7:0]           wr_tag,
  input  logic [7:0]           rd_protocol,
  output ipv4h_pkg::table_rd_t rd
);
  import ipv4h_pkg::*;

  logic [7:0] boxes [TABLE_DEPTH];
  logic [7:0] tags  [TABLE_DEPTH];
  logic       wr_in_range;
  logic       rd_in_range;

  assign wr_in_range = wr_protocol <= 8'(MAX_PROTOCOL);
  assign rd_in_range = rd_protocol <= 8'(MAX_PROTOCOL);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        boxes[i] <= '0;
        tags[i]  <= '0;
      end
    end else if (wr_en && wr_in_range) begin
      boxes[wr_protocol[TBL_IDX_W-1:0]] <= wr_box;
      tags[wr_protocol[TBL_IDX_W-1:0]]  <= wr_tag;
    end
  end

  always_comb begin
    rd.in_range = rd_in_range;
    rd.box      = '0;
    rd.tag      = '0;
    if (rd_in_range) begin
      rd.box = boxes[rd_protocol[TBL_IDX_W-1:0]];
      rd.tag = tags[rd_protocol[TBL_IDX_W-1:0]];
    end
  end

endmodule

// ----- src/ipv4h_send.sv -----
module ipv4h_send (
  input  logic                  clk,
  input  logic                  rst,
  input  ipv4h_pkg::send_ctrl_t ctrl,
  input  logic [7:0]            protocol,
  input  logic [15:0]           buffer_size,
  input  logic [31:0]           dest_address,
  input  logic [31:0]           own_address,
  output logic [15:0]           word,
  output logic                  word_last
);
  import ipv4h_pkg::*;

  logic [WORD_IDX_W-1:0] idx;
  logic [WORD_IDX_W-1:0] idx_next;
  logic [15:0]           ident;
  logic [15:0]           ident_next;
  logic [CSUM_SUM_W-1:0] csum_sum;
  logic [CSUM_SUM_W-1:0] sum_all;
  logic [15:0]           total_len;
  logic [15:0]           ttl_proto;
  logic [16:0]           fold1;
  logic [16:0]           fold2;
  logic [15:0]           csum;

  assign total_len = buffer_size + HEADER_BYTES;
  assign ttl_proto = {SEND_TTL, protocol};

  // checksum word itself counts as zero
  assign sum_all = CSUM_SUM_W'(HEADER_WORD0) + CSUM_SUM_W'(total_len)
                 + CSUM_SUM_W'(ident) + CSUM_SUM_W'(ttl_proto)
                 + CSUM_SUM_W'(own_address[31:16]) + CSUM_SUM_W'(own_address[15:0])
                 + CSUM_SUM_W'(dest_address[31:16]) + CSUM_SUM_W'(dest_address[15:0]);

  assign fold1 = 17'(csum_sum[CSUM_SUM_W-1:16]) + 17'(csum_sum[15:0]);
  assign fold2 = 17'(fold1[16]) + 17'(fold1[15:0]);
  assign csum  = ~fold2[15:0];

  assign word_last = idx == LAST_WORD_IDX;

  always_comb begin
    idx_next   = idx;
    ident_next = ident;
    if (ctrl.active && ctrl.advance) begin
      if (word_last) begin
        idx_next   = '0;
        ident_next = ident + 16'd1;
      end else begin
        idx_next = idx + WORD_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      ident <= '0;
    end else begin
      idx   <= idx_next;
      ident <= ident_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.active && idx == '0) begin
      csum_sum <= sum_all;
    end
  end

  always_comb begin
    case (idx)
      WORD_IDX_W'(0): word = HEADER_WORD0;
      WORD_IDX_W'(1): word = total_len;
      WORD_IDX_W'(2): word = ident;
      WORD_IDX_W'(3): word = 16'h0000;
      WORD_IDX_W'(4): word = ttl_proto;
      CSUM_WORD_IDX:  word = csum;
      WORD_IDX_W'(6): word = own_address[31:16];
      WORD_IDX_W'(7): word = own_address[15:0];
      WORD_IDX_W'(8): word = dest_address[31:16];
      WORD_IDX_W'(9): word = dest_address[15:0];
      default:        word = 16'h0000;
    endcase
  end

endmodule

// ----- src/ipv4_header_engine.sv -----
// IPv4 header engine.
// Input channel (in_valid / in_stall) takes one command per transaction:
// register a protocol handler, check a received header, or build a header.
// Output channel (out_valid / out_stall) returns results, one per transaction.
// Register commands give no result; a receive gives one drop or deliver result;
// a send gives ten 16-bit header words in order, last set on the tenth.
// A command is held in an input register and its result is then registered in
// the output register once it is free. Register commands sustain one per cycle,
// receive commands one per cycle while the output is free; a send occupies the
// header word sequencer until its tenth word is taken, one word per cycle while
// the output is free. The own address register is written through cfg_write /
// cfg_data; the user must do so only while idle, as the block does not enforce
// it. Reset clears the handler table, the identifier counter and both channels,
// and loads the default own address. When out_stall and out_valid are high the
// output holds; a pending receive or send raises in_stall until it drains.
module ipv4_header_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  protocol,
  input  logic [7:0]  handler_box,
  input  logic [7:0]  handler_tag,
  input  logic [7:0]  version_ihl,
  input  logic [15:0] total_length,
  input  logic [15:0] buffer_size,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  deliver_tag,
  output logic [7:0]  deliver_box,
  output logic [31:0] peer_address,
  output logic [5:0]  payload_offset,
  output logic [15:0] payload_size,
  output logic [15:0] header_word,
  output logic        last
);
  import ipv4h_pkg::*;

  logic [31:0] own_address;

  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [7:0]  s1_protocol;
  logic [7:0]  s1_box;
  logic [7:0]  s1_tag;
  logic [7:0]  s1_vihl;
  logic [15:0] s1_tlen;
  logic [15:0] s1_bsize;
  logic [31:0] s1_src;
  logic [31:0] s1_dst;

  logic        accept;
  logic        out_free;
  logic        s1_done;
  logic        produce;
  logic        is_reg;
  logic        is_rcv;
  logic        is_send;

  table_rd_t   tbl;
  send_ctrl_t  send_ctrl;
  logic [15:0] send_word;
  logic        send_last;

  logic        deliver;
  logic [5:0]  hlen;
  logic [15:0] trimmed;
  logic [15:0] size;

  logic [1:0]  kind_next;
  logic [7:0]  tag_next;
  logic [7:0]  box_next;
  logic [31:0] peer_next;
  logic [5:0]  offset_next;
  logic [15:0] size_next;
  logic [15:0] word_next;
  logic        last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDRESS_RESET;
    end else if (cfg_write) begin
      own_address <= cfg_data;
    end
  end

  assign is_reg  = s1_cmd == CMD_REGISTER;
  assign is_rcv  = s1_cmd == CMD_RECEIVE;
  assign is_send = s1_cmd == CMD_SEND;

  assign out_free = !out_valid || !out_stall;
  assign produce  = s1_valid && (is_rcv || is_send);

  always_comb begin
    case (cmd_t'(s1_cmd))
      CMD_RECEIVE: s1_done = s1_valid && out_free;
      CMD_SEND:    s1_done = s1_valid && out_free && send_last;
      default:     s1_done = s1_valid;
    endcase
  end

  assign in_stall = s1_valid && !s1_done;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= cmd;
      s1_protocol <= protocol;
      s1_box      <= handler_box;
      s1_tag      <= handler_tag;
      s1_vihl     <= version_ihl;
      s1_tlen     <= total_length;
      s1_bsize    <= buffer_size;
      s1_src      <= source_address;
      s1_dst      <= dest_address;
    end
  end

  ipv4h_table u_table (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (s1_valid && is_reg),
    .wr_protocol (s1_protocol),
    .wr_box      (s1_box),
    .wr_tag      (s1_tag),
    .rd_protocol (s1_protocol),
    .rd          (tbl)
  );

  assign send_ctrl.active  = s1_valid && is_send;
  assign send_ctrl.advance = out_free;

  ipv4h_send u_send (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (send_ctrl),
    .protocol     (s1_protocol),
    .buffer_size  (s1_bsize),
    .dest_address (s1_dst),
    .own_address  (own_address),
    .word         (send_word),
    .word_last    (send_last)
  );

  assign deliver = s1_vihl[7:4] == IP_VERSION && s1_dst == own_address
                && tbl.in_range && tbl.box != 8'd0;
  assign hlen    = {s1_vihl[3:0], 2'b00};
  assign trimmed = (s1_bsize > s1_tlen) ? s1_tlen : s1_bsize;
  assign size    = (trimmed > 16'(hlen)) ? trimmed - 16'(hlen) : 16'd0;

  always_comb begin
    kind_next   = KIND_DROP;
    tag_next    = '0;
    box_next    = '0;
    peer_next   = '0;
    offset_next = '0;
    size_next   = '0;
    word_next   = '0;
    last_next   = 1'b1;
    if (is_send) begin
      kind_next = KIND_WORD;
      word_next = send_word;
      last_next = send_last;
    end else if (deliver) begin
      kind_next   = KIND_DELIVER;
      tag_next    = tbl.tag;
      box_next    = tbl.box;
      peer_next   = s1_src;
      offset_next = hlen;
      size_next   = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && produce) begin
      kind           <= kind_next;
      deliver_tag    <= tag_next;
      deliver_box    <= box_next;
      peer_address   <= peer_next;
      payload_offset <= offset_next;
      payload_size   <= size_next;
      header_word    <= word_next;
      last           <= last_next;
    end
  end

endmodule
